### hdl/looped_event_window_match_top_macros.svh
// Assertion macros for the looped event window match block.
// Included by the top level; depends on nothing else.
`ifndef LOOPED_EVENT_WINDOW_MATCH_TOP_MACROS_SVH
`define LOOPED_EVENT_WINDOW_MATCH_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LEWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LEWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lewm_pkg.sv
// Shared constants, codes and controller/datapath interface types for
// the looped event window match block. No dependencies.
package lewm_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW          = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int DATA_W  = 32;
    localparam int SPAN_W  = 33;
    localparam int S256_W  = SPAN_W + 8;       // span in 1/256 s
    localparam int TIME_W  = 48;
    localparam int DIFF_W  = TIME_W + 1;
    localparam int BW      = S256_W + 10;      // window bound width, signed
    localparam int LIM_W   = 7;
    localparam int IDX_W   = 8;
    localparam int DCNT_W  = $clog2(TIME_W);

    localparam logic [LIM_W-1:0]  MAX_HITS   = 7'd64;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 33'd86400;

    // Command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_LOAD_ACK  = 2'd0;
    localparam logic [1:0] KIND_CLEAR_ACK = 2'd1;
    localparam logic [1:0] KIND_HIT       = 2'd2;
    localparam logic [1:0] KIND_EMPTY     = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear;
        logic query_cap;
        logic div_step;
        logic fix_a;
        logic sum_b;
        logic wrap_calc;
        logic scan_run;
        logic flush;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic query_void;
        logic div_done;
        logic scan_done;
    } t_dp_stat;

endpackage

### hdl/lewm_dp.sv
// Datapath: span register, event tables, remainder divider, window bounds,
// table scan and result register. Depends on lewm_pkg.
module lewm_dp
    import lewm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic                     i_cfg_we,
    input  logic [SPAN_W-1:0]        i_cfg_wdata,
    input  logic [DATA_W-1:0]        i_entry_offset,
    input  logic [DATA_W-1:0]        i_entry_payload,
    input  logic signed [TIME_W-1:0] i_window_start,
    input  logic signed [TIME_W-1:0] i_window_end,
    input  logic [LIM_W-1:0]         i_hit_limit,
    output logic                     o_strobe,
    output logic [1:0]               o_kind,
    output logic                     o_status,
    output logic [DATA_W-1:0]        o_hit_payload,
    output logic [IDX_W-1:0]         o_hit_index,
    output logic                     o_last
);

    // Tables
    logic [DATA_W-1:0] mem_off [TABLE_DEPTH];
    logic [DATA_W-1:0] mem_pay [TABLE_DEPTH];

    // Control and query state
    logic [SPAN_W-1:0]        r_span;
    logic [CW-1:0]            r_count;
    logic [LIM_W-1:0]         r_lim;
    logic                     r_neg;
    logic [TIME_W-1:0]        r_dvd;
    logic [S256_W-1:0]        r_rem;
    logic [DCNT_W-1:0]        r_dcnt;
    logic signed [DIFF_W-1:0] r_diff;
    logic [S256_W-1:0]        r_a;
    logic signed [BW-1:0]     r_b;
    logic signed [BW-1:0]     r_bw;
    logic                     r_wrap;

    // Scan state
    logic [CW-1:0]     r_ridx;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    logic [DATA_W-1:0] r_rd_off;
    logic [DATA_W-1:0] r_rd_pay;
    logic              r_stop;
    logic [LIM_W-1:0]  r_hits;
    logic              r_pend_vld;
    logic [AW-1:0]     r_pend_idx;
    logic [DATA_W-1:0] r_pend_pay;

    // Result register
    logic              r_o_strobe;
    logic [1:0]        r_o_kind;
    logic              r_o_status;
    logic [DATA_W-1:0] r_o_pay;
    logic [IDX_W-1:0]  r_o_idx;
    logic              r_o_last;

    // Combinational helpers
    logic [S256_W-1:0]        s256;
    logic [LIM_W-1:0]         lim_sat;
    logic                     room;
    logic [S256_W:0]          rem_sh;
    logic signed [DIFF_W-1:0] t0_x;
    logic signed [DIFF_W-1:0] t1_x;
    logic signed [BW-1:0]     bw_calc;
    logic signed [BW-1:0]     off_x;
    logic signed [BW-1:0]     a_x;
    logic                     issue;
    logic                     hit;
    logic [AW+IDX_W-1:0]      pend_idx_x;

    assign s256    = {r_span, 8'd0};
    assign lim_sat = (i_hit_limit > MAX_HITS) ? MAX_HITS : i_hit_limit;
    assign room    = (r_count < CW'(TABLE_DEPTH));
    assign rem_sh  = {r_rem, r_dvd[TIME_W-1]};
    assign t0_x    = DIFF_W'(i_window_start);
    assign t1_x    = DIFF_W'(i_window_end);
    assign bw_calc = r_b - $signed({10'd0, s256});
    assign off_x   = $signed({11'd0, r_rd_off, 8'd0});
    assign a_x     = $signed({10'd0, r_a});
    assign issue   = !r_stop && (r_ridx < r_count);
    assign hit     = r_rd_vld && !r_stop &&
                     ((off_x >= a_x && off_x < r_b) || (r_wrap && off_x < r_bw));
    assign pend_idx_x = {{IDX_W{1'b0}}, r_pend_idx};

    // Status back to the controller
    assign o_stat.query_void = (r_count == '0) || (lim_sat == '0) || (r_span == '0);
    assign o_stat.div_done   = (r_dcnt == '0);
    assign o_stat.scan_done  = r_stop || (!(r_ridx < r_count) && !r_rd_vld);

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            mem_off[r_count[AW-1:0]] <= i_entry_offset;
            mem_pay[r_count[AW-1:0]] <= i_entry_payload;
        end
        r_rd_off <= mem_off[r_ridx[AW-1:0]];
        r_rd_pay <= mem_pay[r_ridx[AW-1:0]];
    end

    // Span register and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span  <= SPAN_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_span <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.load && room) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Query capture, remainder divider and window bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.query_cap) begin
            r_lim  <= lim_sat;
            r_neg  <= i_window_start[TIME_W-1];
            r_dvd  <= i_window_start[TIME_W-1] ? (TIME_W'(0) - i_window_start)
                                               : i_window_start;
            r_rem  <= '0;
            r_dcnt <= DCNT_W'(TIME_W - 1);
            r_diff <= t1_x - t0_x;
        end
        // One quotient bit per cycle, only the remainder is kept
        if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, s256}) begin
                r_rem <= S256_W'(rem_sh - {1'b0, s256});
            end else begin
                r_rem <= rem_sh[S256_W-1:0];
            end
            r_dvd  <= {r_dvd[TIME_W-2:0], 1'b0};
            r_dcnt <= r_dcnt - 1'b1;
        end
        // Negative start folds back into [0, span)
        if (i_cmd.fix_a) begin
            r_a <= (r_neg && r_rem != '0) ? (s256 - r_rem) : r_rem;
        end
        if (i_cmd.sum_b) begin
            r_b <= $signed({10'd0, r_a}) + BW'(r_diff);
        end
        if (i_cmd.wrap_calc) begin
            r_bw   <= bw_calc;
            r_wrap <= !bw_calc[BW-1] && (bw_calc != '0);
        end
    end

    // Scan pipeline: address stage, then compare on registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ridx     <= '0;
            r_rd_vld   <= 1'b0;
            r_stop     <= 1'b0;
            r_hits     <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            if (i_cmd.query_cap) begin
                r_pend_vld <= 1'b0;
            end
            if (i_cmd.wrap_calc) begin
                r_ridx   <= '0;
                r_rd_vld <= 1'b0;
                r_stop   <= 1'b0;
                r_hits   <= '0;
            end
            if (i_cmd.scan_run) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_ridx <= r_ridx + 1'b1;
                end
                if (hit) begin
                    r_pend_vld <= 1'b1;
                    r_hits     <= r_hits + 1'b1;
                    if (r_hits + 1'b1 == r_lim) begin
                        r_stop <= 1'b1;
                    end
                end
            end
        end
    end

    // Pending hit payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run) begin
            r_rd_idx <= r_ridx[AW-1:0];
        end
        if (i_cmd.scan_run && hit) begin
            r_pend_idx <= r_rd_idx;
            r_pend_pay <= r_rd_pay;
        end
    end

    // Result register: one beat per cycle at most
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= i_cmd.load || i_cmd.clear || i_cmd.flush ||
                          (i_cmd.scan_run && hit && r_pend_vld);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_kind   <= KIND_LOAD_ACK;
            r_o_status <= !room;
            r_o_pay    <= '0;
            r_o_idx    <= '0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.clear) begin
            r_o_kind   <= KIND_CLEAR_ACK;
            r_o_status <= 1'b0;
            r_o_pay    <= '0;
            r_o_idx    <= '0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.flush) begin
            r_o_kind   <= r_pend_vld ? KIND_HIT : KIND_EMPTY;
            r_o_status <= 1'b0;
            r_o_pay    <= r_pend_vld ? r_pend_pay : '0;
            r_o_idx    <= r_pend_vld ? pend_idx_x[IDX_W-1:0] : '0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.scan_run && hit && r_pend_vld) begin
            // a newer hit proves the pending one is not the final beat
            r_o_kind   <= KIND_HIT;
            r_o_status <= 1'b0;
            r_o_pay    <= r_pend_pay;
            r_o_idx    <= pend_idx_x[IDX_W-1:0];
            r_o_last   <= 1'b0;
        end
    end

    assign o_strobe      = r_o_strobe;
    assign o_kind        = r_o_kind;
    assign o_status      = r_o_status;
    assign o_hit_payload = r_o_pay;
    assign o_hit_index   = r_o_idx;
    assign o_last        = r_o_last;

endmodule

### hdl/lewm_ctrl.sv
// Controller state machine: sequences load, clear and query work in the
// datapath. Depends on lewm_pkg.
module lewm_ctrl
    import lewm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_command,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_FIXA = 7'b0000100,
        ST_SUMB = 7'b0001000,
        ST_WRAP = 7'b0010000,
        ST_SCAN = 7'b0100000,
        ST_FLSH = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_command)
                        CMD_LOAD:  o_cmd.load  = 1'b1;
                        CMD_CLEAR: o_cmd.clear = 1'b1;
                        CMD_QUERY: begin
                            o_cmd.query_cap = 1'b1;
                            n_state = i_stat.query_void ? ST_FLSH : ST_DIV;
                        end
                        default: ; // unused code: taken, no result
                    endcase
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_FIXA;
                end
            end
            ST_FIXA: begin
                o_cmd.fix_a = 1'b1;
                n_state     = ST_SUMB;
            end
            ST_SUMB: begin
                o_cmd.sum_b = 1'b1;
                n_state     = ST_WRAP;
            end
            ST_WRAP: begin
                o_cmd.wrap_calc = 1'b1;
                n_state         = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = ST_FLSH;
                end
            end
            ST_FLSH: begin
                o_cmd.flush = 1'b1;
                n_state     = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

### hdl/looped_event_window_match_top.sv
// Top level of the looped event window match block: controller plus datapath.
// Depends on lewm_pkg, lewm_ctrl, lewm_dp and the assertion macro header.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  command  | start / busy         | i_command, i_entry_offset, i_entry_payload,
//           |                      | i_window_start, i_window_end, i_hit_limit
//  result   | o_strobe (1 cycle)   | o_kind, o_status, o_hit_payload,
//           |                      | o_hit_index, o_last
//  config   | i_cfg_we             | i_cfg_wdata (span_s)
//
// Load and clear: result beat in the cycle after the command, busy stays low.
// Query: the divider works out the start remainder, the bound states (fix,
// sum, wrap) follow, then one table entry per cycle through the read port
// and a flush state; a void query goes straight to the flush state.
// Synchronous active-low reset; table contents survive it, the count clears.
// The receiver cannot stall: each beat is valid for exactly one cycle.
`include "looped_event_window_match_top_macros.svh"

module looped_event_window_match_top
    import lewm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_command,
    input  logic [DATA_W-1:0]        i_entry_offset,
    input  logic [DATA_W-1:0]        i_entry_payload,
    input  logic signed [TIME_W-1:0] i_window_start,
    input  logic signed [TIME_W-1:0] i_window_end,
    input  logic [LIM_W-1:0]         i_hit_limit,
    input  logic                     i_cfg_we,
    input  logic [SPAN_W-1:0]        i_cfg_wdata,
    output logic                     o_strobe,
    output logic [1:0]               o_kind,
    output logic                     o_status,
    output logic [DATA_W-1:0]        o_hit_payload,
    output logic [IDX_W-1:0]         o_hit_index,
    output logic                     o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Terms used by the checks
    logic take_load;
    logic take_query;
    logic load_kind;
    logic load_beat;
    logic query_fin;
    logic full_beat;

    lewm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .o_busy    (busy)
    );

    lewm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_entry_offset  (i_entry_offset),
        .i_entry_payload (i_entry_payload),
        .i_window_start  (i_window_start),
        .i_window_end    (i_window_end),
        .i_hit_limit     (i_hit_limit),
        .o_strobe        (o_strobe),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_hit_payload   (o_hit_payload),
        .o_hit_index     (o_hit_index),
        .o_last          (o_last)
    );

    // Checks
    assign take_load  = start && !busy && (i_command == CMD_LOAD);
    assign take_query = start && !busy && (i_command == CMD_QUERY);
    assign load_kind  = (o_kind == KIND_LOAD_ACK);
    assign load_beat  = o_strobe && load_kind && o_last;
    assign query_fin  = o_strobe && o_last && (o_kind == KIND_HIT || o_kind == KIND_EMPTY);
    assign full_beat  = o_strobe && o_status;

    `LEWM_ASSERT_NEXT(a_load_ack, i_clk, i_rst_n, take_load, load_beat, "load without ack beat")
    `LEWM_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, take_query, busy, "query did not raise busy")
    `LEWM_ASSERT_NOW(a_query_end, i_clk, i_rst_n, query_fin, !busy, "final query beat while busy")
    `LEWM_ASSERT_NOW(a_status_kind, i_clk, i_rst_n, full_beat, load_kind, "full status off a load")

endmodule
